[hw/rtl/wheel_encoder_odometry_assert.svh]
// ----------------------------------------------------------------------------
// Wheel encoder odometry assertion macros
// Macros for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef WHEEL_ENCODER_ODOMETRY_ASSERT_SVH
`define WHEEL_ENCODER_ODOMETRY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WEO_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WEO_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/weo_pkg.sv]
// ----------------------------------------------------------------------------
// Wheel encoder odometry package
// Payload types, controller commands and arithmetic constants.
// ----------------------------------------------------------------------------
package weo_pkg;

    localparam int TPC_W = 16;
    localparam logic [TPC_W-1:0] TPC_RESET = 16'd220;

    // Count extension thresholds.
    localparam logic signed [16:0] WRAP_JUMP  = 17'sd50000;
    localparam logic [15:0]        WRAP_SPLIT = 16'd30000;

    // Speed numerator is |d| * 25600 * 1000000 = |d| * 390625 * 2^16.
    localparam logic [18:0] SPEED_MUL   = 19'd390625;
    localparam int          SPEED_SHIFT = 16;
    localparam logic [13:0] FWD_MUL     = 14'd12800;

    localparam int SPD_PROD_W = 50;
    localparam int FWD_PROD_W = 47;
    localparam int NUM_W      = SPD_PROD_W + SPEED_SHIFT;
    localparam int DEN_W      = 48;
    localparam int QUO_W      = 32;
    localparam int DIV_STEPS  = QUO_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [15:0]        left_raw;
        logic [15:0]        right_raw;
        logic [31:0]        now_us;
        logic signed [31:0] heading;
    } in_t;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic signed [31:0] left_speed;
        logic signed [31:0] right_speed;
        logic signed [31:0] forward_change;
        logic signed [31:0] total_distance;
        logic signed [31:0] turn_change;
        logic signed [31:0] total_angle;
    } out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXTEND,
        S_DELTA,
        S_RIGHT,
        S_MUL_L,
        S_ABS_F,
        S_MUL_F,
        S_LSTART,
        S_LWAIT,
        S_RSTART,
        S_RWAIT,
        S_FSTART,
        S_FWAIT,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEL_LEFT,
        SEL_RIGHT,
        SEL_FWD
    } div_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     extend;
        logic     delta;
        logic     right_diff;
        logic     mul_left;
        logic     abs_fwd;
        logic     mul_fwd;
        logic     div_start;
        div_sel_t div_sel;
        logic     div_take;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

[hw/rtl/weo_div.sv]
// ----------------------------------------------------------------------------
// Wheel encoder odometry divider
// Restoring divider, one quotient bit per cycle, signed saturating result.
// ----------------------------------------------------------------------------
`include "wheel_encoder_odometry_assert.svh"

module weo_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [weo_pkg::NUM_W-1:0] num,
    input  logic [weo_pkg::DEN_W-1:0] den,
    input  logic                      neg,
    output logic                      done,
    output logic [weo_pkg::QUO_W-1:0] result
);
    import weo_pkg::*;

    localparam int HI_W = NUM_W - QUO_W;
    localparam logic [DIV_CNT_W-1:0] LAST_CNT = DIV_CNT_W'(DIV_STEPS - 1);
    localparam logic [QUO_W-1:0] SAT_POS = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] SAT_NEG = {1'b1, {(QUO_W-1){1'b0}}};

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [DEN_W-1:0]     den_reg;
    logic                 neg_reg;
    logic                 ovf_reg;
    logic                 zero_reg;

    logic [DEN_W-1:0]     num_hi;
    logic [DEN_W:0]       rem_sh;
    logic [DEN_W:0]       rem_sub;
    logic                 ge;
    logic [QUO_W-1:0]     quo_neg;

    assign num_hi  = {{(DEN_W-HI_W){1'b0}}, num[NUM_W-1:QUO_W]};
    assign rem_sh  = {rem_reg, quo_reg[QUO_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign quo_neg = {QUO_W{1'b0}} - quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The numerator bits above QUO_W are preloaded: when they are below the divisor the
    // quotient fits in QUO_W bits, otherwise the result saturates; a zero divisor gives zero.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= num_hi;
            quo_reg  <= num[QUO_W-1:0];
            den_reg  <= den;
            neg_reg  <= neg;
            ovf_reg  <= num_hi >= den;
            zero_reg <= den == '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    always_comb begin
        if (zero_reg) begin
            result = '0;
        end else if (ovf_reg || quo_reg[QUO_W-1]) begin
            result = neg_reg ? SAT_NEG : SAT_POS;
        end else begin
            result = neg_reg ? quo_neg : quo_reg;
        end
    end

    assign done = done_reg;

    `WEO_ASSERT_SAME(a_start_idle, aclk, aresetn, start, !busy_reg, "divider restarted while busy")
    `WEO_ASSERT_NEXT(a_done_pulse, aclk, aresetn, done_reg, !done_reg, "done held for two cycles")
    `WEO_ASSERT_NEXT(a_done_last, aclk, aresetn, busy_reg && !start && cnt_reg == LAST_CNT, done_reg && !busy_reg, "division did not finish on the last step")

endmodule

[hw/rtl/weo_ctrl.sv]
// ----------------------------------------------------------------------------
// Wheel encoder odometry controller
// Sequences the datapath steps, the three divisions and the result load.
// ----------------------------------------------------------------------------
module weo_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  weo_pkg::dp_status_t    status,
    output weo_pkg::dp_cmd_t       cmd
);
    import weo_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_valid) state_next = S_EXTEND;
            S_EXTEND: state_next = S_DELTA;
            S_DELTA:  state_next = S_RIGHT;
            S_RIGHT:  state_next = S_MUL_L;
            S_MUL_L:  state_next = S_ABS_F;
            S_ABS_F:  state_next = S_MUL_F;
            S_MUL_F:  state_next = S_LSTART;
            S_LSTART: state_next = S_LWAIT;
            S_LWAIT:  if (status.div_done) state_next = S_RSTART;
            S_RSTART: state_next = S_RWAIT;
            S_RWAIT:  if (status.div_done) state_next = S_FSTART;
            S_FSTART: state_next = S_FWAIT;
            S_FWAIT:  if (status.div_done) state_next = S_OUT;
            S_OUT:    if (status.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            S_EXTEND: cmd.extend     = 1'b1;
            S_DELTA:  cmd.delta      = 1'b1;
            S_RIGHT:  cmd.right_diff = 1'b1;
            S_MUL_L:  cmd.mul_left   = 1'b1;
            S_ABS_F:  cmd.abs_fwd    = 1'b1;
            S_MUL_F:  cmd.mul_fwd    = 1'b1;
            S_LSTART: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SEL_LEFT;
            end
            S_LWAIT: begin
                cmd.div_sel  = SEL_LEFT;
                cmd.div_take = status.div_done;
            end
            S_RSTART: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SEL_RIGHT;
            end
            S_RWAIT: begin
                cmd.div_sel  = SEL_RIGHT;
                cmd.div_take = status.div_done;
            end
            S_FSTART: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = SEL_FWD;
            end
            S_FWAIT: begin
                cmd.div_sel  = SEL_FWD;
                cmd.div_take = status.div_done;
            end
            S_OUT:   cmd.load_out = status.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

[hw/rtl/weo_dp.sv]
// ----------------------------------------------------------------------------
// Wheel encoder odometry datapath
// Count extension, deltas, scaling products, shared divider and result register.
// ----------------------------------------------------------------------------
module weo_dp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  weo_pkg::in_t              s_data,
    input  logic                      cfg_we,
    input  logic [weo_pkg::TPC_W-1:0] cfg_wdata,
    input  weo_pkg::dp_cmd_t          cmd,
    output weo_pkg::dp_status_t       status,
    output logic                      m_valid,
    input  logic                      m_ready,
    output weo_pkg::out_t             m_data
);
    import weo_pkg::*;

    function automatic logic [15:0] next_rounds(input logic [15:0] raw,
                                                input logic [15:0] prev,
                                                input logic [15:0] rounds);
        logic signed [16:0] jump;
        logic [15:0]        res;
        jump = $signed({1'b0, raw}) - $signed({1'b0, prev});
        res  = rounds;
        if (jump > WRAP_JUMP || jump < -WRAP_JUMP) begin
            if (raw > WRAP_SPLIT) begin
                res = rounds - 16'd1;
            end else begin
                res = rounds + 16'd1;
            end
        end
        return res;
    endfunction

    // Configuration and odometry state.
    logic [TPC_W-1:0] tpc_reg;
    logic [15:0]      l_prev_raw_reg;
    logic [15:0]      l_rounds_reg;
    logic [15:0]      r_prev_raw_reg;
    logic [15:0]      r_rounds_reg;
    logic [31:0]      l_last_reg;
    logic [31:0]      r_last_reg;
    logic [31:0]      last_time_reg;
    logic [31:0]      prev_heading_reg;
    logic [31:0]      distance_acc_reg;
    logic [31:0]      angle_acc_reg;
    logic             m_valid_reg;

    // Per-request working registers.
    in_t                   in_reg;
    logic [31:0]           lcount_reg;
    logic [31:0]           rext_reg;
    logic [31:0]           rcount_reg;
    logic [31:0]           ld_reg;
    logic [31:0]           rd_reg;
    logic [31:0]           dt_reg;
    logic [31:0]           turn_reg;
    logic [DEN_W-1:0]      den_spd_reg;
    logic [31:0]           mag_l_reg;
    logic                  neg_l_reg;
    logic [31:0]           mag_r_reg;
    logic                  neg_r_reg;
    logic [32:0]           sum_reg;
    logic [32:0]           mag_f_reg;
    logic                  neg_f_reg;
    logic [SPD_PROD_W-1:0] num_l_reg;
    logic [SPD_PROD_W-1:0] num_r_reg;
    logic [FWD_PROD_W-1:0] num_f_reg;
    logic [31:0]           spd_l_reg;
    logic [31:0]           spd_r_reg;
    logic [31:0]           fwd_reg;
    out_t                  m_data_reg;

    logic [15:0]      l_rounds_new;
    logic [15:0]      r_rounds_new;
    logic [TPC_W-1:0] tpc_eff;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_neg;
    logic             div_done;
    logic [QUO_W-1:0] div_result;
    logic [31:0]      dist_sum;
    logic             out_free;
    out_t             out_next;

    assign l_rounds_new = next_rounds(in_reg.left_raw, l_prev_raw_reg, l_rounds_reg);
    assign r_rounds_new = next_rounds(in_reg.right_raw, r_prev_raw_reg, r_rounds_reg);
    // A scale of zero is treated as one.
    assign tpc_eff  = (tpc_reg == '0) ? TPC_W'(1) : tpc_reg;
    assign dist_sum = distance_acc_reg + fwd_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        case (cmd.div_sel)
            SEL_LEFT: begin
                div_num = {num_l_reg, {SPEED_SHIFT{1'b0}}};
                div_den = den_spd_reg;
                div_neg = neg_l_reg;
            end
            SEL_RIGHT: begin
                div_num = {num_r_reg, {SPEED_SHIFT{1'b0}}};
                div_den = den_spd_reg;
                div_neg = neg_r_reg;
            end
            default: begin
                div_num = {{(NUM_W-FWD_PROD_W){1'b0}}, num_f_reg};
                div_den = {{(DEN_W-TPC_W){1'b0}}, tpc_eff};
                div_neg = neg_f_reg;
            end
        endcase
    end

    weo_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .neg     (div_neg),
        .done    (div_done),
        .result  (div_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpc_reg          <= TPC_RESET;
            l_prev_raw_reg   <= '0;
            l_rounds_reg     <= '0;
            r_prev_raw_reg   <= '0;
            r_rounds_reg     <= '0;
            l_last_reg       <= '0;
            r_last_reg       <= '0;
            last_time_reg    <= '0;
            prev_heading_reg <= '0;
            distance_acc_reg <= '0;
            angle_acc_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                tpc_reg <= cfg_wdata;
            end
            if (cmd.extend) begin
                l_prev_raw_reg <= in_reg.left_raw;
                l_rounds_reg   <= l_rounds_new;
                r_prev_raw_reg <= in_reg.right_raw;
                r_rounds_reg   <= r_rounds_new;
            end
            if (cmd.delta) begin
                l_last_reg       <= lcount_reg;
                last_time_reg    <= in_reg.now_us;
                prev_heading_reg <= in_reg.heading;
            end
            if (cmd.right_diff) begin
                r_last_reg    <= rcount_reg;
                angle_acc_reg <= angle_acc_reg + turn_reg;
            end
            if (cmd.load_out) begin
                distance_acc_reg <= dist_sum;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.extend) begin
            lcount_reg <= {l_rounds_new, in_reg.left_raw};
            rext_reg   <= {r_rounds_new, in_reg.right_raw};
        end
        if (cmd.delta) begin
            rcount_reg <= 32'd0 - rext_reg;
            ld_reg     <= lcount_reg - l_last_reg;
            dt_reg     <= in_reg.now_us - last_time_reg;
            turn_reg   <= in_reg.heading - prev_heading_reg;
        end
        if (cmd.right_diff) begin
            rd_reg      <= rcount_reg - r_last_reg;
            den_spd_reg <= {{(DEN_W-TPC_W){1'b0}}, tpc_eff} * {{(DEN_W-32){1'b0}}, dt_reg};
            neg_l_reg   <= ld_reg[31];
            mag_l_reg   <= ld_reg[31] ? 32'd0 - ld_reg : ld_reg;
        end
        if (cmd.mul_left) begin
            sum_reg   <= {ld_reg[31], ld_reg} + {rd_reg[31], rd_reg};
            neg_r_reg <= rd_reg[31];
            mag_r_reg <= rd_reg[31] ? 32'd0 - rd_reg : rd_reg;
            num_l_reg <= {{(SPD_PROD_W-32){1'b0}}, mag_l_reg}
                       * {{(SPD_PROD_W-19){1'b0}}, SPEED_MUL};
        end
        if (cmd.abs_fwd) begin
            neg_f_reg <= sum_reg[32];
            mag_f_reg <= sum_reg[32] ? 33'd0 - sum_reg : sum_reg;
            num_r_reg <= {{(SPD_PROD_W-32){1'b0}}, mag_r_reg}
                       * {{(SPD_PROD_W-19){1'b0}}, SPEED_MUL};
        end
        if (cmd.mul_fwd) begin
            num_f_reg <= {{(FWD_PROD_W-33){1'b0}}, mag_f_reg}
                       * {{(FWD_PROD_W-14){1'b0}}, FWD_MUL};
        end
        if (cmd.div_take) begin
            case (cmd.div_sel)
                SEL_LEFT:  spd_l_reg <= div_result;
                SEL_RIGHT: spd_r_reg <= div_result;
                default:   fwd_reg   <= div_result;
            endcase
        end
        if (cmd.load_out) begin
            m_data_reg <= out_next;
        end
    end

    always_comb begin
        out_next.left_count     = $signed(lcount_reg);
        out_next.right_count    = $signed(rcount_reg);
        out_next.left_speed     = $signed(spd_l_reg);
        out_next.right_speed    = $signed(spd_r_reg);
        out_next.forward_change = $signed(fwd_reg);
        out_next.total_distance = $signed(dist_sum);
        out_next.turn_change    = $signed(turn_reg);
        out_next.total_angle    = $signed(angle_acc_reg);
    end

    assign status.div_done = div_done;
    assign status.out_free = out_free;
    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;

endmodule

[hw/rtl/wheel_encoder_odometry.sv]
// ----------------------------------------------------------------------------
// Wheel encoder odometry
// Encoder count extension, wheel speeds, forward distance and turn angle.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel takes one sample request (both raw encoder counters, the
// microsecond timestamp and the gyro heading); the m_ channel returns one
// result request per sample. Both use valid/ready. The user must write the
// tick scale register through cfg_we/cfg_wdata only while the block is idle;
// the block itself does not enforce this. Each request runs through six
// short datapath steps, then three 32-step divisions (left speed, right
// speed, forward travel) one after another on one shared restoring divider.
// A new request is taken only once the previous result has been loaded.
// The result sits in an output register, so the next request is accepted
// while a result is still waiting; that request's result then waits until
// the register is taken. Reset clears all odometry state, restores the tick
// scale to 220 and drops m_valid.
// ----------------------------------------------------------------------------
module wheel_encoder_odometry (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  weo_pkg::in_t              s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output weo_pkg::out_t             m_data,
    input  logic                      cfg_we,
    input  logic [weo_pkg::TPC_W-1:0] cfg_wdata
);
    import weo_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    weo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    weo_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
